>>> src/mek_pkg.sv
// Package for the multi-event key scanner: state codes, event codes, register map.
package mek_pkg;

  localparam int NUM_KEYS_DEF = 8;

  localparam int KEY_W   = 3;
  localparam int EVENT_W = 3;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // One-hot slot state.
  typedef enum logic [8:0] {
    ST_IDLE        = 9'b0_0000_0001,
    ST_DB_PRESS    = 9'b0_0000_0010,
    ST_PRESSED     = 9'b0_0000_0100,
    ST_HELD        = 9'b0_0000_1000,
    ST_DB_RELEASE  = 9'b0_0001_0000,
    ST_WAIT_DOUBLE = 9'b0_0010_0000,
    ST_DB_PRESS2   = 9'b0_0100_0000,
    ST_PRESSED2    = 9'b0_1000_0000,
    ST_RELEASE2    = 9'b1_0000_0000
  } key_state_t;

  typedef logic [EVENT_W-1:0] key_event_t;

  localparam key_event_t EV_NONE   = 3'd0;
  localparam key_event_t EV_BRIEF  = 3'd1;
  localparam key_event_t EV_SHORT  = 3'd2;
  localparam key_event_t EV_LONG   = 3'd3;
  localparam key_event_t EV_DOUBLE = 3'd4;

  // Register indexes (byte address / 4).
  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_DEBOUNCE = 3'd0;
  localparam reg_idx_t REG_LONG     = 3'd1;
  localparam reg_idx_t REG_DOUBLE   = 3'd2;
  localparam reg_idx_t REG_BRIEF    = 3'd3;
  localparam reg_idx_t REG_ACTIVE   = 3'd4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd300;
  localparam logic [CFG_W-1:0] BRIEF_RST    = 16'd200;
  localparam logic             ACTIVE_RST   = 1'b0;

endpackage

>>> src/multi_event_key_scanner.sv
// Top level of the multi-event key scanner: per-slot debounce and click/long/double events.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | in        | in_valid / in_ready     | in_key_index, in_pin_level, in_now_ms
//   out     | out       | out_valid / out_ready   | out_key_slot, out_key_event
//   cfg     | in        | psel/penable/pwrite     | paddr, pwdata, prdata (pready = 1)
//
// One request per cycle sustained while out_ready is high, through the input
// register and then the result register. The slot state file is read and
// written in the same cycle the request moves into the result register, so
// back-to-back requests to one slot see each other's updates with no stall.
// Reset (rst_n low, synchronous) puts every slot in idle with zero time stamps
// and loads the register defaults.
// When out_ready is low the result register holds; the input register still
// fills once, then in_ready drops until the result is taken.
module multi_event_key_scanner #(
  parameter int NUM_KEYS = mek_pkg::NUM_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mek_pkg::KEY_W-1:0]     in_key_index,
  input  logic                          in_pin_level,
  input  logic [mek_pkg::TIME_W-1:0]    in_now_ms,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mek_pkg::KEY_W-1:0]     out_key_slot,
  output logic [mek_pkg::EVENT_W-1:0]   out_key_event,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mek_pkg::PADDR_W-1:0]   paddr,
  input  logic [mek_pkg::PDATA_W-1:0]   pwdata,
  output logic [mek_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mek_pkg::*;

  // Only eight slots are addressable by a 3-bit index.
  localparam int SLOTS = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_r;
  logic [CFG_W-1:0] double_r;
  logic [CFG_W-1:0] brief_r;
  logic             active_r;

  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
      double_r   <= DOUBLE_RST;
      brief_r    <= BRIEF_RST;
      active_r   <= ACTIVE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEBOUNCE: debounce_r <= pwdata[CFG_W-1:0];
        REG_LONG:     long_r     <= pwdata[CFG_W-1:0];
        REG_DOUBLE:   double_r   <= pwdata[CFG_W-1:0];
        REG_BRIEF:    brief_r    <= pwdata[CFG_W-1:0];
        REG_ACTIVE:   active_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE: prdata = {{(PDATA_W-CFG_W){1'b0}}, debounce_r};
      REG_LONG:     prdata = {{(PDATA_W-CFG_W){1'b0}}, long_r};
      REG_DOUBLE:   prdata = {{(PDATA_W-CFG_W){1'b0}}, double_r};
      REG_BRIEF:    prdata = {{(PDATA_W-CFG_W){1'b0}}, brief_r};
      REG_ACTIVE:   prdata = {{(PDATA_W-1){1'b0}}, active_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic              s1_valid_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic              s1_pin_r;
  logic [TIME_W-1:0] s1_now_r;

  logic              out_valid_r;
  logic [KEY_W-1:0]  out_slot_r;
  key_event_t        out_event_r;

  logic s1_adv;
  logic in_take;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_key_r <= in_key_index;
      s1_pin_r <= in_pin_level;
      s1_now_r <= in_now_ms;
    end
  end

  // ---------------- slot state file ----------------
  key_state_t        st_r      [SLOTS];
  logic [TIME_W-1:0] press_r   [SLOTS];
  logic [TIME_W-1:0] rel_r     [SLOTS];
  logic [TIME_W-1:0] first_r   [SLOTS];

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              down;
  key_state_t        cur_st;
  logic [TIME_W-1:0] cur_press;
  logic [TIME_W-1:0] cur_rel;
  logic [TIME_W-1:0] cur_first;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_rel;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] debounce_x;
  logic [TIME_W-1:0] long_x;
  logic [TIME_W-1:0] double_x;
  logic [TIME_W-1:0] brief_x;

  key_state_t        st_nxt;
  logic [TIME_W-1:0] press_nxt;
  logic [TIME_W-1:0] rel_nxt;
  logic [TIME_W-1:0] first_nxt;
  key_event_t        event_nxt;

  assign idx       = s1_key_r[IDX_W-1:0];
  assign in_range  = 32'(s1_key_r) < NUM_KEYS;
  assign down      = (s1_pin_r == active_r);
  assign cur_st    = st_r[idx];
  assign cur_press = press_r[idx];
  assign cur_rel   = rel_r[idx];
  assign cur_first = first_r[idx];

  // modulo-2^32 elapsed times
  assign since_press = s1_now_r - cur_press;
  assign since_rel   = s1_now_r - cur_rel;
  assign held        = cur_rel - cur_press;

  assign debounce_x = {{(TIME_W-CFG_W){1'b0}}, debounce_r};
  assign long_x     = {{(TIME_W-CFG_W){1'b0}}, long_r};
  assign double_x   = {{(TIME_W-CFG_W){1'b0}}, double_r};
  assign brief_x    = {{(TIME_W-CFG_W){1'b0}}, brief_r};

  always_comb begin
    st_nxt    = cur_st;
    press_nxt = cur_press;
    rel_nxt   = cur_rel;
    first_nxt = cur_first;
    event_nxt = EV_NONE;
    unique case (cur_st)
      ST_IDLE: begin
        if (down) begin
          press_nxt = s1_now_r;
          st_nxt    = ST_DB_PRESS;
        end
      end
      ST_DB_PRESS: begin
        if (since_press >= debounce_x) begin
          if (down) begin
            press_nxt = s1_now_r;
            st_nxt    = ST_PRESSED;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (down) begin
          if (since_press >= long_x) begin
            st_nxt    = ST_HELD;
            event_nxt = EV_LONG;
          end
        end else begin
          rel_nxt = s1_now_r;
          st_nxt  = ST_DB_RELEASE;
        end
      end
      ST_DB_RELEASE: begin
        if (since_rel >= debounce_x) begin
          if (!down) begin
            // too short a press is a glitch, not a click
            if (held < debounce_x) begin
              st_nxt = ST_IDLE;
            end else begin
              first_nxt = held;
              st_nxt    = ST_WAIT_DOUBLE;
            end
          end else begin
            st_nxt = ST_PRESSED;   // bounce: keep original press stamp
          end
        end
      end
      ST_WAIT_DOUBLE: begin
        if (down) begin
          press_nxt = s1_now_r;
          // late second press drops the pending click
          st_nxt    = (since_rel <= double_x) ? ST_DB_PRESS2 : ST_DB_PRESS;
        end else if (since_rel >= double_x) begin
          st_nxt    = ST_IDLE;
          event_nxt = (cur_first < brief_x) ? EV_BRIEF : EV_SHORT;
        end
      end
      ST_DB_PRESS2: begin
        if (since_press >= debounce_x) begin
          st_nxt = down ? ST_PRESSED2 : ST_WAIT_DOUBLE;
        end
      end
      ST_PRESSED2: begin
        if (!down) begin
          rel_nxt = s1_now_r;
          st_nxt  = ST_RELEASE2;
        end
      end
      ST_RELEASE2: begin
        if (since_rel >= debounce_x) begin
          if (!down) begin
            st_nxt    = ST_IDLE;
            event_nxt = EV_DOUBLE;
          end else begin
            st_nxt = ST_PRESSED2;
          end
        end
      end
      ST_HELD: begin
        if (!down) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i]    <= ST_IDLE;
        press_r[i] <= '0;
        rel_r[i]   <= '0;
        first_r[i] <= '0;
      end
    end else if (s1_adv && in_range) begin
      st_r[idx]    <= st_nxt;
      press_r[idx] <= press_nxt;
      rel_r[idx]   <= rel_nxt;
      first_r[idx] <= first_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_slot_r  <= s1_key_r;
      out_event_r <= in_range ? event_nxt : EV_NONE;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_slot  = out_slot_r;
  assign out_key_event = out_event_r;

endmodule

>>> test/key_scan_checker.sv
// Checker for the key scanner: watches the channels and the register port, predicts events.
`timescale 1ns / 1ps

module key_scan_checker #(
  parameter int NUM_KEYS = mek_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [mek_pkg::KEY_W-1:0]   in_key_index,
  input  logic                        in_pin_level,
  input  logic [mek_pkg::TIME_W-1:0]  in_now_ms,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mek_pkg::KEY_W-1:0]   out_key_slot,
  input  logic [mek_pkg::EVENT_W-1:0] out_key_event,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [mek_pkg::PADDR_W-1:0] paddr,
  input  logic [mek_pkg::PDATA_W-1:0] pwdata,
  input  logic [mek_pkg::PDATA_W-1:0] prdata,
  output int                          mismatches,
  output int                          pending
);
  import mek_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] slot;
    key_event_t       kev;
  } key_report_t;

  // Register copies as seen on the bus
  logic [CFG_W-1:0] deb_lim, long_lim, gap_lim, brief_lim;
  logic             act_lvl;

  // Per-slot scan state
  key_state_t        slot_state  [NUM_KEYS];
  logic [TIME_W-1:0] pressed_at  [NUM_KEYS];
  logic [TIME_W-1:0] released_at [NUM_KEYS];
  logic [TIME_W-1:0] first_hold  [NUM_KEYS];

  key_report_t expected_reports [$];

  task automatic log_mismatch(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  function automatic key_event_t next_key_event(input logic [KEY_W-1:0] k, input logic pin,
                                                input logic [TIME_W-1:0] now);
    logic              down;
    logic [TIME_W-1:0] since_press, since_rel, held;
    key_event_t        kev;
    // slot beyond the configured count: no state touched
    if (32'(k) >= NUM_KEYS) return EV_NONE;
    down = (pin == act_lvl);
    kev = EV_NONE;
    since_press = now - pressed_at[k];
    since_rel = now - released_at[k];
    case (slot_state[k])
      ST_IDLE: begin
        if (down) begin
          pressed_at[k] = now;
          slot_state[k] = ST_DB_PRESS;
        end
      end
      ST_DB_PRESS: begin
        if (since_press >= deb_lim) begin
          if (down) begin
            pressed_at[k] = now;
            slot_state[k] = ST_PRESSED;
          end else begin
            slot_state[k] = ST_IDLE;
          end
        end
      end
      ST_PRESSED: begin
        if (down) begin
          if (since_press >= long_lim) begin
            slot_state[k] = ST_HELD;
            kev = EV_LONG;
          end
        end else begin
          released_at[k] = now;
          slot_state[k] = ST_DB_RELEASE;
        end
      end
      ST_HELD: begin
        if (!down) slot_state[k] = ST_IDLE;
      end
      ST_DB_RELEASE: begin
        if (since_rel >= deb_lim) begin
          if (!down) begin
            held = released_at[k] - pressed_at[k];
            if (held < deb_lim) begin
              slot_state[k] = ST_IDLE;
            end else begin
              first_hold[k] = held;
              slot_state[k] = ST_WAIT_DOUBLE;
            end
          end else begin
            // bounce: back to pressed, original press stamp kept
            slot_state[k] = ST_PRESSED;
          end
        end
      end
      ST_WAIT_DOUBLE: begin
        if (down) begin
          // late second press drops the pending click
          pressed_at[k] = now;
          slot_state[k] = (since_rel <= gap_lim) ? ST_DB_PRESS2 : ST_DB_PRESS;
        end else if (since_rel >= gap_lim) begin
          slot_state[k] = ST_IDLE;
          kev = (first_hold[k] < brief_lim) ? EV_BRIEF : EV_SHORT;
        end
      end
      ST_DB_PRESS2: begin
        if (since_press >= deb_lim) slot_state[k] = down ? ST_PRESSED2 : ST_WAIT_DOUBLE;
      end
      ST_PRESSED2: begin
        if (!down) begin
          released_at[k] = now;
          slot_state[k] = ST_RELEASE2;
        end
      end
      ST_RELEASE2: begin
        if (since_rel >= deb_lim) begin
          if (!down) begin
            slot_state[k] = ST_IDLE;
            kev = EV_DOUBLE;
          end else begin
            slot_state[k] = ST_PRESSED2;
          end
        end
      end
      default: slot_state[k] = ST_IDLE;
    endcase
    return kev;
  endfunction

  always @(posedge clk) begin
    key_report_t       rep;
    logic [31:0]       rd_want;
    if (!rst_n) begin
      deb_lim = DEBOUNCE_RST;
      long_lim = LONG_RST;
      gap_lim = DOUBLE_RST;
      brief_lim = BRIEF_RST;
      act_lvl = ACTIVE_RST;
      for (int i = 0; i < NUM_KEYS; i++) begin
        slot_state[i] = ST_IDLE;
        pressed_at[i] = '0;
        released_at[i] = '0;
        first_hold[i] = '0;
      end
      expected_reports.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_DEBOUNCE: deb_lim = pwdata[CFG_W-1:0];
            REG_LONG:     long_lim = pwdata[CFG_W-1:0];
            REG_DOUBLE:   gap_lim = pwdata[CFG_W-1:0];
            REG_BRIEF:    brief_lim = pwdata[CFG_W-1:0];
            REG_ACTIVE:   act_lvl = pwdata[0];
            default: ;
          endcase
        end else begin
          case (paddr[4:2])
            REG_DEBOUNCE: rd_want = {16'b0, deb_lim};
            REG_LONG:     rd_want = {16'b0, long_lim};
            REG_DOUBLE:   rd_want = {16'b0, gap_lim};
            REG_BRIEF:    rd_want = {16'b0, brief_lim};
            REG_ACTIVE:   rd_want = {31'b0, act_lvl};
            default:      rd_want = prdata;  // reads of unmapped addresses are not compared
          endcase
          if (prdata !== rd_want) log_mismatch("register read", rd_want, prdata);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          log_mismatch("unexpected result", '0, 32'({out_key_slot, out_key_event}));
        end else begin
          rep = expected_reports.pop_front();
          if (out_key_slot !== rep.slot)
            log_mismatch("key_slot", 32'(rep.slot), 32'(out_key_slot));
          if (out_key_event !== rep.kev)
            log_mismatch("key_event", 32'(rep.kev), 32'(out_key_event));
        end
      end
      if (in_valid && in_ready) begin
        rep.slot = in_key_index;
        rep.kev = next_key_event(in_key_index, in_pin_level, in_now_ms);
        expected_reports.push_back(rep);
      end
    end
    pending = expected_reports.size();
  end

endmodule

>>> test/tb_top.sv
// Testbench top for the key scanner: clock, reset, stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_top;
  import mek_pkg::*;

  localparam int       HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int       STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam reg_idx_t REG_UNMAPPED = 3'd7;  // address with no register behind it

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [KEY_W-1:0]     in_key_index;
  logic                 in_pin_level;
  logic [TIME_W-1:0]    in_now_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic [KEY_W-1:0]     out_key_slot;
  logic [EVENT_W-1:0]   out_key_event;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int mismatches;
  int pending;

  // Stimulus-side copy of the registers; the pin level that means "pressed"
  // depends on active_level, so gestures are built from it.
  logic [CFG_W-1:0] cfg_deb   = DEBOUNCE_RST;
  logic [CFG_W-1:0] cfg_long  = LONG_RST;
  logic [CFG_W-1:0] cfg_gap   = DOUBLE_RST;
  logic [CFG_W-1:0] cfg_brief = BRIEF_RST;
  logic             cfg_act   = ACTIVE_RST;

  logic [TIME_W-1:0] sim_ms;          // running millisecond clock of the stimulus
  bit                slot_down [8];   // level each slot is currently being held at
  int                sent;            // requests accepted so far
  bit                quiet;           // no random idling on either side
  bit                hold_req;        // ask the receiver for a long hold-off
  int                idle_cycles;

  multi_event_key_scanner dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_index  (in_key_index),
    .in_pin_level  (in_pin_level),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_slot  (out_key_slot),
    .out_key_event (out_key_event),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  key_scan_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_index  (in_key_index),
    .in_pin_level  (in_pin_level),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_slot  (out_key_slot),
    .out_key_event (out_key_event),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("multi_event_key_scanner test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random back-pressure, or a long counted hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // One scan sample. Entered and left at a falling edge; valid stays high
  // into the next request unless an idle gap is drawn.
  task automatic tap(input int k, input bit down, input logic [TIME_W-1:0] t);
    int gap_len;
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      gap_len = $urandom_range(1, 4);
      repeat (gap_len) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_key_index <= k[KEY_W-1:0];
    in_pin_level <= down ? cfg_act : ~cfg_act;
    in_now_ms    <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Sender pauses until every result is back, plus the pipeline latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Setup then access phase; psel drops between back-to-back calls.
  task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Junk in the upper bits checks that writes are masked to the register width;
  // the readback lets the checker compare every register.
  task automatic set_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                            input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] brf,
                            input logic act);
    logic [31:0] junk;
    reg_idx_t    idx;
    drain();
    junk = $urandom;
    apb_access(1'b1, REG_DEBOUNCE, {junk[31:16], deb});
    apb_access(1'b1, REG_LONG, {junk[15:0], lng});
    apb_access(1'b1, REG_DOUBLE, {junk[23:8], gap});
    apb_access(1'b1, REG_BRIEF, {junk[30:15], brf});
    apb_access(1'b1, REG_ACTIVE, {junk[31:1], act});
    apb_access(1'b1, REG_UNMAPPED, $urandom);
    cfg_deb   = deb;
    cfg_long  = lng;
    cfg_gap   = gap;
    cfg_brief = brf;
    cfg_act   = act;
    for (idx = REG_DEBOUNCE; idx <= REG_ACTIVE; idx++) apb_access(1'b0, idx, '0);
  endtask

  // Durations cluster around the thresholds so every branch gets hit.
  function automatic int unsigned pick_dur();
    int unsigned base, jit;
    case ($urandom_range(7))
      0: base = $urandom_range(cfg_deb / 2);
      1: base = 32'(cfg_deb);
      2: base = 32'(cfg_brief);
      3: base = 32'(cfg_gap);
      4: base = 32'(cfg_long);
      5: base = 32'(cfg_long) + 32'(cfg_deb);
      6: base = 2 * 32'(cfg_long) + 2 * 32'(cfg_deb);
      default: base = $urandom_range(3 * cfg_long + 50);
    endcase
    jit = $urandom_range(8);
    return (base + jit > 4) ? base + jit - 4 : 0;
  endfunction

  // Hold one slot at a level for dur ms, sampled a random number of times.
  // Other slots are sampled in between at their own held level, which also
  // lets their pending clicks time out; now and then the pin bounces.
  task automatic hold_level(input int k, input bit down, input int unsigned dur);
    int unsigned n, t0;
    int          other;
    n = $urandom_range(1, 8);
    t0 = sim_ms;
    slot_down[k] = down;
    for (int unsigned i = 1; i <= n; i++) begin
      if ($urandom_range(99) < 20) begin
        other = $urandom_range(7);
        tap(other, slot_down[other], sim_ms);
      end
      tap(k, ($urandom_range(99) < 4) ? !down : down, sim_ms);
      sim_ms = t0 + dur * i / n;
    end
  endtask

  // Press/release, sometimes followed by a second press for a double click.
  task automatic gesture();
    int k;
    k = $urandom_range(7);
    hold_level(k, 1'b1, pick_dur());
    hold_level(k, 1'b0, pick_dur());
    if ($urandom_range(1)) begin
      hold_level(k, 1'b1, pick_dur());
      hold_level(k, 1'b0, pick_dur());
    end
  endtask

  // Mostly gestures; one in ten is a lone sample with a random time stamp.
  task automatic run_items(input int n);
    int goal;
    goal = sent + n;
    while (sent < goal) begin
      if ($urandom_range(9) == 0) tap($urandom_range(7), 1'($urandom_range(1)), $urandom);
      else gesture();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_key_index = '0;
    in_pin_level = 1'b0;
    in_now_ms    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sim_ms       = '0;
    sent         = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    idle_cycles  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset register values (debounce 20, long 1000,
    // double window 300, brief 200, pressed = pin low).
    // brief click on slot 0
    tap(0, 1, 1000); tap(0, 1, 1020); tap(0, 0, 1100); tap(0, 0, 1120); tap(0, 0, 1420);
    // short click on slot 1 with a bounce inside the release debounce
    tap(1, 1, 2000); tap(1, 1, 2030); tap(1, 0, 2300); tap(1, 1, 2320);
    tap(1, 0, 2400); tap(1, 0, 2420); tap(1, 0, 2720);
    // double click on slot 2
    tap(2, 1, 3000); tap(2, 1, 3020); tap(2, 0, 3050); tap(2, 0, 3070);
    tap(2, 1, 3100); tap(2, 1, 3120); tap(2, 0, 3150); tap(2, 0, 3170);
    // long press then release straight out of held on slot 3
    tap(3, 1, 4000); tap(3, 1, 4020); tap(3, 1, 5020); tap(3, 0, 5021);
    // slot 7: press across the 32-bit time wrap, then a second press too late
    tap(7, 1, 32'hFFFF_FFF0); tap(7, 1, 4); tap(7, 0, 50); tap(7, 0, 70); tap(7, 1, 500);

    // Low extremes: every threshold zero, pressed = pin high
    set_config('0, '0, '0, '0, 1'b1);
    sim_ms = $urandom;
    run_items(150);

    // High extremes; long holds run the time through the wrap
    set_config('1, '1, '1, '1, 1'b0);
    sim_ms = 32'hFFFF_0000;
    run_items(150);

    // Fast timing, many events, no idling on either side
    set_config(16'd5, 16'd100, 16'd40, 16'd30, 1'b1);
    quiet = 1'b1;
    run_items(250);
    quiet = 1'b0;

    // Random settings; the first one opens with a long receiver hold-off
    // while requests keep coming so the block backs up its input.
    for (int p = 0; p < 4; p++) begin
      set_config(16'($urandom_range(40)), 16'($urandom_range(1500)),
                 16'($urandom_range(400)), 16'($urandom_range(400)),
                 1'($urandom_range(1)));
      if (p == 0) hold_req = 1'b1;
      run_items(220);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("multi_event_key_scanner test passed");
    end else begin
      $display("multi_event_key_scanner test failed");
    end
    $finish;
  end

endmodule
